FILE: hw/rtl/tcp_pkg.sv
// Shared types, codes and cell sizes for the text cursor placer.
`timescale 1ns / 1ps

package tcp_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BIG_FONT      = 2'd2;

    localparam logic [10:0] SCREEN_WIDTH_RST  = 11'd128;
    localparam logic [10:0] SCREEN_HEIGHT_RST = 11'd128;

    // Request kinds (s_tuser)
    localparam logic REQ_SET_CURSOR = 1'b0;
    localparam logic REQ_CHAR       = 1'b1;

    // Command kinds (m_tuser)
    localparam logic CMD_DRAW  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Character codes
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;

    // Cell geometry
    localparam logic [4:0] BIG_CELL_W   = 5'd8;
    localparam logic [4:0] BIG_CELL_H   = 5'd16;
    localparam logic [4:0] SMALL_CELL_W = 5'd6;
    localparam logic [4:0] SMALL_CELL_H = 5'd8;

    typedef struct packed {
        logic [10:0] screen_width;
        logic [10:0] screen_height;
        logic        big_font;
    } cfg_t;

    // One queued job: an optional clear followed by an optional draw
    typedef struct packed {
        logic        has_clear;
        logic        has_draw;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  glyph;
    } cmd_entry_t;

    function automatic logic [4:0] cell_w(input logic big);
        return big ? BIG_CELL_W : SMALL_CELL_W;
    endfunction

    function automatic logic [4:0] cell_h(input logic big);
        return big ? BIG_CELL_H : SMALL_CELL_H;
    endfunction

endpackage

FILE: hw/rtl/tcp_front.sv
// Front end: accepts requests, tracks the cursor and queues draw/clear jobs.
`timescale 1ns / 1ps

module tcp_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tcp_pkg::cfg_t          cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   req_type,
    input  logic [15:0]            start_x,
    input  logic [15:0]            start_y,
    input  logic [7:0]             char_code,
    output logic                   push_valid,
    input  logic                   push_ready,
    output tcp_pkg::cmd_entry_t    push_entry
);

    logic [15:0] cursor_x_reg, cursor_x_next;
    logic [15:0] cursor_y_reg, cursor_y_next;

    logic        accept;
    logic [15:0] cw, ch;
    logic        ovf;
    logic [15:0] cx0, cy0;
    logic        is_nl, is_bs;
    logic [15:0] adv_x;
    logic [16:0] wrap_sum;
    logic        wrap;
    logic [15:0] bs_x, bs_y;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    assign cw = {11'd0, tcp_pkg::cell_w(cfg.big_font)};
    assign ch = {11'd0, tcp_pkg::cell_h(cfg.big_font)};

    // cursor_y > H - ch, done without a sign: cursor_y + ch > H
    assign ovf = ({1'b0, cursor_y_reg} + {1'b0, ch}) > {6'd0, cfg.screen_height};
    assign cx0 = ovf ? 16'd0 : cursor_x_reg;
    assign cy0 = ovf ? 16'd0 : cursor_y_reg;

    assign is_nl = (char_code == tcp_pkg::CHAR_NEWLINE);
    assign is_bs = (char_code == tcp_pkg::CHAR_BACKSPACE);

    // Backspace: step back one cell, or wrap to the end of the row above
    always_comb begin
        if (cx0 >= cw) begin
            bs_x = cx0 - cw;
            bs_y = cy0;
        end else begin
            bs_x = {5'd0, cfg.screen_width} - cw;
            bs_y = cy0 - ch;
        end
    end

    // Printable wrap: big cells x > W - 8, small cells x >= W - 6
    assign adv_x    = cx0 + cw;
    assign wrap_sum = {1'b0, adv_x} + {1'b0, cw};
    assign wrap     = cfg.big_font ? (wrap_sum >  {6'd0, cfg.screen_width})
                                   : (wrap_sum >= {6'd0, cfg.screen_width});

    always_comb begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        push_valid    = 1'b0;
        push_entry    = '0;
        push_entry.has_clear = ovf;
        push_entry.has_draw  = !is_nl;
        if (accept) begin
            case (req_type)
                tcp_pkg::REQ_SET_CURSOR: begin
                    cursor_x_next = start_x;
                    cursor_y_next = start_y;
                end
                tcp_pkg::REQ_CHAR: begin
                    push_valid = ovf || !is_nl;
                    if (is_nl) begin
                        cursor_x_next = 16'd0;
                        cursor_y_next = cy0 + ch;
                    end else if (is_bs) begin
                        cursor_x_next    = bs_x;
                        cursor_y_next    = bs_y;
                        push_entry.x     = bs_x;
                        push_entry.y     = bs_y;
                        push_entry.glyph = tcp_pkg::CHAR_SPACE;
                    end else begin
                        push_entry.x     = cx0;
                        push_entry.y     = cy0;
                        push_entry.glyph = char_code;
                        cursor_x_next    = wrap ? 16'd0 : adv_x;
                        cursor_y_next    = wrap ? (cy0 + ch) : cy0;
                    end
                end
                default: begin
                    cursor_x_next = cursor_x_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg <= 16'd0;
            cursor_y_reg <= 16'd0;
        end else begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
        end
    end

endmodule

FILE: hw/rtl/tcp_queue.sv
// Small job queue between the front and back ends.
`timescale 1ns / 1ps

module tcp_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  tcp_pkg::cmd_entry_t    push_data,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output tcp_pkg::cmd_entry_t    pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tcp_pkg::cmd_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: hw/rtl/tcp_back.sv
// Back end: expands queued jobs into clear and draw beats on the output register.
`timescale 1ns / 1ps

module tcp_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tcp_pkg::cfg_t          cfg,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  tcp_pkg::cmd_entry_t    pop_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [39:0]            m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);

    logic        out_valid_reg, out_valid_next;
    logic        out_cmd_reg, out_cmd_next;
    logic        out_last_reg, out_last_next;
    logic [15:0] out_x_reg, out_x_next;
    logic [15:0] out_y_reg, out_y_next;
    logic [7:0]  out_g_reg, out_g_next;
    logic        clr_sent_reg, clr_sent_next;

    logic        out_free, load, emit_clear, off_edge;
    logic [15:0] ch, draw_x, draw_y;

    assign ch         = {11'd0, tcp_pkg::cell_h(cfg.big_font)};
    assign out_free   = !out_valid_reg || m_tready;
    assign load       = out_free && pop_valid;
    assign emit_clear = pop_data.has_clear && !clr_sent_reg;
    // Hold the job after its clear beat when a draw still follows
    assign pop_ready  = load && !(emit_clear && pop_data.has_draw);

    // A draw past the right edge lands at the start of the next row
    assign off_edge = pop_data.x >= {5'd0, cfg.screen_width};
    assign draw_x   = off_edge ? 16'd0 : pop_data.x;
    assign draw_y   = off_edge ? (pop_data.y + ch) : pop_data.y;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_cmd_next   = out_cmd_reg;
        out_last_next  = out_last_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_g_next     = out_g_reg;
        clr_sent_next  = clr_sent_reg;
        if (load) begin
            out_valid_next = 1'b1;
            if (emit_clear) begin
                out_cmd_next  = tcp_pkg::CMD_CLEAR;
                out_x_next    = 16'd0;
                out_y_next    = 16'd0;
                out_g_next    = 8'd0;
                out_last_next = !pop_data.has_draw;
                clr_sent_next = pop_data.has_draw;
            end else begin
                out_cmd_next  = tcp_pkg::CMD_DRAW;
                out_x_next    = draw_x;
                out_y_next    = draw_y;
                out_g_next    = pop_data.glyph;
                out_last_next = 1'b1;
                clr_sent_next = 1'b0;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            clr_sent_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            clr_sent_reg  <= clr_sent_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_cmd_reg  <= out_cmd_next;
        out_last_reg <= out_last_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_g_reg    <= out_g_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_cmd_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_g_reg, out_y_reg, out_x_reg};

endmodule

FILE: hw/rtl/text_cursor_placer.sv
// Top level of the text cursor placer: config registers, front end, queue, back end.
`timescale 1ns / 1ps

// Turns a byte stream of text into glyph draw and screen clear commands at
// pixel positions, for 8x16 cells (big_font=1) or 6x8 cells (big_font=0). A
// beat with s_tuser=0 loads the cursor from start_x/start_y and produces no
// output. A beat with s_tuser=1 handles char_code: newline moves to column 0
// of the next text row, backspace steps back one cell (wrapping to the end of
// the row above) and draws a space, any other byte is drawn and advances the
// cursor. Before each character, a cursor row past the bottom of the screen
// emits a clear command and homes the cursor. The front end takes one input
// beat per clock while the queue has room, since the whole cursor update is
// combinational, and posts at most one job per beat into a QUEUE_DEPTH entry
// queue; s_tready drops only while that queue is full. The back end drains
// that queue into a registered output at one beat per clock while m_tready
// allows; a character other than newline that also clears the screen yields
// a clear beat and a draw beat and so holds the back end for both, which the
// queue absorbs for short bursts. The first output beat of an input enters the
// queue when that input is accepted and then the output register, which drives
// m_tvalid. m_tlast marks the final beat caused by one input beat.
// Write configuration only while idle.

module text_cursor_placer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_wdata,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // start_x[15:0], start_y[31:16], char_code[39:32]
    input  logic        s_tuser,   // req_type
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pos_x[15:0], pos_y[31:16], glyph_code[39:32]
    output logic        m_tuser,   // command
    output logic        m_tlast    // last beat for this input
);

    tcp_pkg::cfg_t       cfg_reg;
    tcp_pkg::cmd_entry_t push_entry, pop_entry;
    logic                push_valid, push_ready;
    logic                pop_valid, pop_ready;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width  <= tcp_pkg::SCREEN_WIDTH_RST;
            cfg_reg.screen_height <= tcp_pkg::SCREEN_HEIGHT_RST;
            cfg_reg.big_font      <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tcp_pkg::CFG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_wdata;
                tcp_pkg::CFG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_wdata;
                tcp_pkg::CFG_BIG_FONT:      cfg_reg.big_font      <= cfg_wdata[0];
                default:                    cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Front end: cursor tracking and job classification
    tcp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .req_type   (s_tuser),
        .start_x    (s_tdata[15:0]),
        .start_y    (s_tdata[31:16]),
        .char_code  (s_tdata[39:32]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // Decoupling queue
    tcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_entry)
    );

    // Back end: expand jobs into output beats
    tcp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_entry),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: hw/rtl/tcp_checker.sv
// Port-level checker for the text cursor placer, bound to the top level.
`timescale 1ns / 1ps

module tcp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // Stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // Clear beats carry no position or glyph
    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == tcp_pkg::CMD_CLEAR) |-> (m_tdata == 40'd0))
        else $error("clear beat with nonzero data");

    // A draw is always the final beat of its input
    a_draw_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == tcp_pkg::CMD_DRAW) |-> m_tlast)
        else $error("draw beat without tlast");

    // A clear that is not last is followed at once by its draw
    a_clear_then_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && (m_tuser == tcp_pkg::CMD_CLEAR) && !m_tlast
        |=> m_tvalid && (m_tuser == tcp_pkg::CMD_DRAW))
        else $error("clear beat not followed by its draw");

endmodule

bind text_cursor_placer tcp_checker u_tcp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: bench/text_cursor_placer_test.sv
// Self-checking regression bench for the text cursor placer.
`timescale 1ns / 1ps

module text_cursor_placer_test;

    // Cycles to let pass once nothing is pending, covering the queue and output
    // register path plus a beat of no-output work (set cursor, plain newline) inside.
    localparam int DRAIN_CYCLES = 8;
    localparam int DRAIN_GUARD  = 20000;

    // One output beat as the display side sees it
    typedef struct packed {
        logic        cmd;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  glyph;
        logic        last;
    } disp_cmd_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = tcp_pkg::CFG_SCREEN_WIDTH;
    logic [10:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;   // start_x[15:0], start_y[31:16], char_code[39:32]
    logic        s_tuser   = tcp_pkg::REQ_SET_CURSOR;   // req_type
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // pos_x[15:0], pos_y[31:16], glyph_code[39:32]
    logic        m_tuser;          // command
    logic        m_tlast;

    // Shadow of the block: screen registers and the cursor
    logic [10:0] scr_w     = tcp_pkg::SCREEN_WIDTH_RST;
    logic [10:0] scr_h     = tcp_pkg::SCREEN_HEIGHT_RST;
    logic        big_cells = 1'b0;
    logic [15:0] cur_x     = '0;
    logic [15:0] cur_y     = '0;

    // Display commands predicted but not yet seen on the output, oldest first
    disp_cmd_t draw_cmds_due[$];

    int  n_errors = 0;
    // Sender pacing: when low, the input side drives back-to-back beats
    bit  pace_on  = 1'b1;

    always #4 aclk = ~aclk;

    text_cursor_placer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // ------------------------------------------------------------------
    // Cursor prediction
    // ------------------------------------------------------------------

    // Queue a glyph draw; a cell that starts past the right edge lands at
    // column 0 one text row down, while the cursor itself stays put.
    function automatic void post_draw(input logic [15:0] x, input logic [15:0] y,
                                      input logic [7:0] g, input int cell_h_px);
        disp_cmd_t d;
        d.cmd   = tcp_pkg::CMD_DRAW;
        d.x     = x;
        d.y     = y;
        d.glyph = g;
        d.last  = 1'b1;
        if (x >= {5'd0, scr_w}) begin
            d.x = '0;
            d.y = y + cell_h_px;
        end
        draw_cmds_due.push_back(d);
    endfunction

    // Advance the shadow cursor by one accepted input beat and queue the
    // display commands it causes.
    function automatic void place_char(input logic kind, input logic [15:0] sx,
                                       input logic [15:0] sy, input logic [7:0] c);
        int        cw;
        int        chh;
        int        xi;
        int        yi;
        logic      wrap;
        disp_cmd_t clr;
        cw  = big_cells ? 8 : 6;
        chh = big_cells ? 16 : 8;
        if (kind == tcp_pkg::REQ_SET_CURSOR) begin
            cur_x = sx;
            cur_y = sy;
            return;
        end
        // Bottom overflow check is signed, so a screen shorter than one
        // cell clears before every character.
        yi = cur_y;
        clr.cmd   = tcp_pkg::CMD_CLEAR;
        clr.x     = '0;
        clr.y     = '0;
        clr.glyph = '0;
        clr.last  = 1'b1;
        if (yi > int'(scr_h) - chh) begin
            cur_x = '0;
            cur_y = '0;
        end else begin
            clr.cmd = tcp_pkg::CMD_DRAW;   // mark: no clear this beat
        end
        if (c == tcp_pkg::CHAR_NEWLINE) begin
            if (clr.cmd == tcp_pkg::CMD_CLEAR)
                draw_cmds_due.push_back(clr);
            cur_x = '0;
            cur_y = cur_y + chh;
            return;
        end
        if (clr.cmd == tcp_pkg::CMD_CLEAR) begin
            clr.last = 1'b0;
            draw_cmds_due.push_back(clr);
        end
        if (c == tcp_pkg::CHAR_BACKSPACE) begin
            // Step back one cell, or to the end of the row above from column 0
            if (cur_x >= cw) begin
                cur_x = cur_x - cw;
            end else begin
                cur_x = scr_w - cw;
                cur_y = cur_y - chh;
            end
            post_draw(cur_x, cur_y, tcp_pkg::CHAR_SPACE, chh);
            return;
        end
        post_draw(cur_x, cur_y, c, chh);
        cur_x = cur_x + cw;
        xi    = cur_x;
        if (big_cells)
            wrap = xi > int'(scr_w) - 8;
        else
            wrap = xi >= int'(scr_w) - 6;
        if (wrap) begin
            cur_x = '0;
            cur_y = cur_y + chh;
        end
    endfunction

    // Text form of one display command for reports
    function automatic string fmt_cmd(input disp_cmd_t d);
        return $sformatf("cmd=%0d x=%0d y=%0d glyph=%h last=%0d",
                         d.cmd, d.x, d.y, d.glyph, d.last);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Drive one input beat after a random gap and predict it once accepted.
    // Valid stays high after acceptance so a zero gap gives back-to-back beats.
    task automatic send_item(input logic kind, input logic [15:0] sx,
                             input logic [15:0] sy, input logic [7:0] c);
        int gap;
        gap = pace_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {c, sy, sx};
        do @(posedge aclk); while (!s_tready);
        place_char(kind, sx, sy, c);
    endtask

    // Unused fields carry random bits so every tdata bit toggles
    task automatic put_char(input logic [7:0] c);
        send_item(tcp_pkg::REQ_CHAR, 16'($urandom), 16'($urandom), c);
    endtask

    task automatic move_cursor(input logic [15:0] x, input logic [15:0] y);
        send_item(tcp_pkg::REQ_SET_CURSOR, x, y, 8'($urandom));
    endtask

    // Drop valid and wait until every predicted beat has come out, then
    // hold DRAIN_CYCLES longer for work that makes no output.
    task automatic settle();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (draw_cmds_due.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write all three registers on consecutive edges; call only when idle
    task automatic set_config(input logic [10:0] w, input logic [10:0] h,
                              input logic big);
        cfg_wr_en <= 1'b1;
        cfg_index <= tcp_pkg::CFG_SCREEN_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_index <= tcp_pkg::CFG_SCREEN_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_index <= tcp_pkg::CFG_BIG_FONT;
        cfg_wdata <= {10'd0, big};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        scr_w     = w;
        scr_h     = h;
        big_cells = big;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Run on reset values of the registers and the cursor; byte zero prints
    task automatic test_reset_values();
        put_char(8'h41);
        put_char(8'h00);
        settle();
    endtask

    // Fill one small-cell row until it wraps, with the byte extremes
    task automatic test_row_wrap();
        set_config(11'd32, 11'd32, 1'b0);
        move_cursor(16'd0, 16'd0);
        put_char(8'hFF);
        put_char(8'h7F);
        put_char(8'h80);
        put_char(8'h41);
        put_char(8'h42);
        settle();
    endtask

    // Backspace from column 0 climbs to the row above; newline draws nothing
    task automatic test_edit_keys();
        put_char(tcp_pkg::CHAR_BACKSPACE);
        put_char(tcp_pkg::CHAR_BACKSPACE);
        put_char(tcp_pkg::CHAR_NEWLINE);
        settle();
    endtask

    // A cursor past the right edge draws at column 0 one row down, and the
    // x advance wraps modulo 2^16
    task automatic test_right_edge();
        move_cursor(16'hFFFF, 16'd0);
        put_char(8'h5A);
        settle();
    endtask

    // A 1024x1024 screen with big cells: clear before a char, a lone clear on
    // newline, and backspace from the origin wrapping y below zero
    task automatic test_bottom_clear();
        set_config(11'd1024, 11'd1024, 1'b1);
        move_cursor(16'd0, 16'd1009);
        put_char(8'h5A);
        move_cursor(16'd0, 16'hFFFF);
        put_char(tcp_pkg::CHAR_NEWLINE);
        move_cursor(16'd0, 16'd0);
        put_char(tcp_pkg::CHAR_BACKSPACE);
        put_char(8'h61);
        settle();
    endtask

    // Screen shorter than a big cell: every character clears first
    task automatic test_tiny_screen();
        set_config(11'd8, 11'd8, 1'b1);
        put_char(8'h61);
        put_char(tcp_pkg::CHAR_NEWLINE);
        put_char(tcp_pkg::CHAR_BACKSPACE);
        settle();
    endtask

    function automatic logic [10:0] pick_dim();
        case ($urandom_range(0, 5))
            0:       return 11'd8;
            1:       return 11'd1024;
            2, 3:    return 11'($urandom_range(8, 64));
            default: return 11'($urandom_range(8, 1024));
        endcase
    endfunction

    // Mostly running text on extreme and then random screens, with some cursor
    // loads aimed at the edges and some fully random ones
    task automatic test_random_text(input int n_phases, input int per_phase);
        int r;
        int lo_y;
        logic [10:0] w;
        logic [10:0] h;
        for (int p = 0; p < n_phases; p++) begin
            case (p)
                0:       begin w = 11'd8;    h = 11'd8;    end
                1:       begin w = 11'd1024; h = 11'd1024; end
                2:       begin w = 11'd8;    h = 11'd1024; end
                3:       begin w = 11'd1024; h = 11'd8;    end
                default: begin w = pick_dim(); h = pick_dim(); end
            endcase
            set_config(w, h, p < 4 ? logic'(p[0]) : logic'($urandom_range(0, 1)));
            for (int i = 0; i < per_phase; i++) begin
                // Alternate paced stretches with back-to-back ones
                if (i % 32 == 0)
                    pace_on = ($urandom_range(0, 3) != 0);
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    case ($urandom_range(0, 3))
                        0, 1: move_cursor(16'($urandom_range(0, scr_w)),
                                          16'($urandom_range(0, int'(scr_h) + 16)));
                        2: begin
                            lo_y = int'(scr_h) - 16;
                            if (lo_y < 0)
                                lo_y = 0;
                            move_cursor(16'($urandom_range(0, scr_w + 8)),
                                        16'($urandom_range(lo_y, lo_y + 32)));
                        end
                        default: move_cursor(16'($urandom), 16'($urandom));
                    endcase
                end else if (r < 20) begin
                    put_char(tcp_pkg::CHAR_NEWLINE);
                end else if (r < 32) begin
                    put_char(tcp_pkg::CHAR_BACKSPACE);
                end else begin
                    put_char(8'($urandom_range(0, 255)));
                end
            end
            settle();
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure and beat checking
    // ------------------------------------------------------------------
    initial begin : beat_checker
        disp_cmd_t want;
        disp_cmd_t got;
        int        stall;
        int        beats;
        bit        stall_on;
        beats    = 0;
        stall_on = 1'b1;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (beats % 32 == 0)
                stall_on = ($urandom_range(0, 3) != 0);
            stall = stall_on ? $urandom_range(0, 11) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            beats++;
            got.cmd   = m_tuser;
            got.x     = m_tdata[15:0];
            got.y     = m_tdata[31:16];
            got.glyph = m_tdata[39:32];
            got.last  = m_tlast;
            if (draw_cmds_due.size() == 0) begin
                n_errors++;
                $display("%0t: mismatch expected no beat, actual %s",
                         $time, fmt_cmd(got));
            end else begin
                want = draw_cmds_due.pop_front();
                if (got !== want) begin
                    n_errors++;
                    $display("%0t: mismatch expected %s, actual %s",
                             $time, fmt_cmd(want), fmt_cmd(got));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : run_tests
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_row_wrap();
        test_edit_keys();
        test_right_edge();
        test_bottom_clear();
        test_tiny_screen();
        test_random_text(10, 85);
        // settle() ended the run; anything still pending never arrived
        if (draw_cmds_due.size() != 0) begin
            n_errors++;
            $display("%0t: %0d commands never arrived", $time, draw_cmds_due.size());
        end
        if (n_errors == 0)
            $display("text_cursor_placer regression: pass");
        else
            $display("text_cursor_placer regression: fail");
        $finish;
    end

    // Hard stop well past the slowest correct run
    initial begin : watchdog
        #5_000_000;
        $display("text_cursor_placer regression: fail");
        $finish;
    end

endmodule

FILE: text_cursor_placer.f
hw/rtl/tcp_pkg.sv
hw/rtl/tcp_front.sv
hw/rtl/tcp_queue.sv
hw/rtl/tcp_back.sv
hw/rtl/text_cursor_placer.sv
hw/rtl/tcp_checker.sv
bench/text_cursor_placer_test.sv
